// ===== rtl/rlsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rlsa_pkg
// Shared types, register indexes and helpers for the run-length smear unit.
// ----------------------------------------------------------------------------
package rlsa_pkg;

  localparam int RUN_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_H_THRESH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_THRESH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

  localparam logic [RUN_W-1:0]      RUN_MAX          = 12'hfff;
  localparam logic [RUN_W-1:0]      H_THRESH_RST     = 12'd2000;
  localparam logic [RUN_W-1:0]      V_THRESH_RST     = 12'd2000;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [RUN_W-1:0]      h_thresh;
    logic [RUN_W-1:0]      v_thresh;
    logic [CFG_DATA_W-1:0] frame_width;
    logic [CFG_DATA_W-1:0] frame_height;
  } rlsa_cfg_t;

  // item handed from the row stage to the column stage
  typedef struct packed {
    logic             pixel;
    logic [RUN_W-1:0] row_fill;
    logic             last;
    logic             first_row;
  } rlsa_item_t;

  // one column memory entry
  typedef struct packed {
    logic             seen;
    logic [RUN_W-1:0] run;
  } rlsa_col_t;

  localparam int COL_W = $bits(rlsa_col_t);

  function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
    return (r == RUN_MAX) ? RUN_MAX : r + 1'b1;
  endfunction

endpackage

// ===== rtl/rlsa_run_length_smear_unit.sv =====
// ----------------------------------------------------------------------------
// rlsa_run_length_smear_unit
// Run-length smoothing front end: row and column gap fill lengths per pixel.
// ----------------------------------------------------------------------------
// Takes one binary pixel per cycle in raster order while in_stall is low and
// returns it with the row and column fill lengths, one result per pixel. The
// column runs live in a MAX_WIDTH x 13 bit memory with one read and one write
// port; each pixel reads its column entry when accepted and writes it back as
// it leaves s1, with a bypass for back-to-back use of the same column (frames
// one pixel wide), sustaining one pixel per cycle while out_stall is low. The
// memory needs no clearing: row 0 of each frame ignores and rewrites it.
// Users write thresholds and frame size via cfg_ only while idle (unchecked).
module rlsa_run_length_smear_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_pixel_black,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pixel_out,
  output logic [rlsa_pkg::RUN_W-1:0]      out_row_fill_length,
  output logic [rlsa_pkg::RUN_W-1:0]      out_column_fill_length,
  output logic                            out_frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rlsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlsa_pkg::*;

  rlsa_cfg_t                 cfg;
  rlsa_item_t                item;
  logic [$clog2(MAX_WIDTH)-1:0] col_addr;
  logic                      accept;

  rlsa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlsa_row_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_row (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .accept      (accept),
    .pixel_black (in_pixel_black),
    .col_addr    (col_addr),
    .item        (item)
  );

  rlsa_col_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_col (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .accept       (accept),
    .rd_addr      (col_addr),
    .item_in      (item),
    .v_thresh     (cfg.v_thresh),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel_out),
    .out_row_fill (out_row_fill_length),
    .out_col_fill (out_column_fill_length),
    .out_last     (out_frame_last)
  );

endmodule

// ===== rtl/rlsa_ram.sv =====
// ----------------------------------------------------------------------------
// rlsa_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rlsa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rlsa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rlsa_cfg_regs
// Threshold and frame size registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module rlsa_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rlsa_pkg::rlsa_cfg_t              cfg
);
  import rlsa_pkg::*;

  rlsa_cfg_t cfg_r;
  rlsa_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_H_THRESH:     cfg_nxt.h_thresh     = cfg_data[RUN_W-1:0];
        REG_V_THRESH:     cfg_nxt.v_thresh     = cfg_data[RUN_W-1:0];
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data;
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data;
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h_thresh     <= H_THRESH_RST;
      cfg_r.v_thresh     <= V_THRESH_RST;
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/rlsa_row_stage.sv =====
// ----------------------------------------------------------------------------
// rlsa_row_stage
// Raster position counters and the horizontal white run; forms the row fill.
// ----------------------------------------------------------------------------
module rlsa_row_stage #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rlsa_pkg::rlsa_cfg_t            cfg,
  input  logic                           accept,
  input  logic                           pixel_black,
  output logic [$clog2(MAX_WIDTH)-1:0]   col_addr,
  output rlsa_pkg::rlsa_item_t           item
);
  import rlsa_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CWX = (XW + 1 > CFG_DATA_W) ? XW + 1 : CFG_DATA_W;
  localparam int CWY = (YW + 1 > CFG_DATA_W) ? YW + 1 : CFG_DATA_W;
  localparam logic [CWX-1:0] W_MAX = CWX'(MAX_WIDTH);
  localparam logic [CWY-1:0] H_MAX = CWY'(MAX_HEIGHT);

  logic [XW-1:0]    col_pos_r, col_pos_nxt;
  logic [YW-1:0]    row_pos_r, row_pos_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic             seen_r, seen_nxt;

  logic [CWX-1:0] fw_ext, w_eff;
  logic [CWY-1:0] fh_ext, h_eff;
  logic           row_end, frame_end;
  logic [RUN_W-1:0] row_fill;

  // zero size acts as one, oversize is clipped to the storage limit
  assign fw_ext = CWX'(cfg.frame_width);
  assign fh_ext = CWY'(cfg.frame_height);
  assign w_eff  = (fw_ext == '0) ? CWX'(1) : ((fw_ext > W_MAX) ? W_MAX : fw_ext);
  assign h_eff  = (fh_ext == '0) ? CWY'(1) : ((fh_ext > H_MAX) ? H_MAX : fh_ext);

  assign row_end   = (CWX'(col_pos_r) + CWX'(1)) >= w_eff;
  assign frame_end = row_end && ((CWY'(row_pos_r) + CWY'(1)) >= h_eff);

  assign row_fill = (pixel_black && seen_r && (run_r <= cfg.h_thresh)) ? run_r : '0;

  assign col_addr       = col_pos_r;
  assign item.pixel     = pixel_black;
  assign item.row_fill  = row_fill;
  assign item.last      = frame_end;
  assign item.first_row = (row_pos_r == '0);

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    run_nxt     = run_r;
    seen_nxt    = seen_r;
    if (accept) begin
      if (pixel_black) begin
        run_nxt  = '0;
        seen_nxt = 1'b1;
      end else begin
        run_nxt = run_inc(run_r);
      end
      if (row_end) begin
        col_pos_nxt = '0;
        run_nxt     = '0;
        seen_nxt    = 1'b0;
        row_pos_nxt = frame_end ? '0 : row_pos_r + 1'b1;
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      run_r     <= '0;
      seen_r    <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      run_r     <= run_nxt;
      seen_r    <= seen_nxt;
    end
  end

endmodule

// ===== rtl/rlsa_col_stage.sv =====
// ----------------------------------------------------------------------------
// rlsa_col_stage
// Column memory read-modify-write, vertical fill and the output register.
// ----------------------------------------------------------------------------
module rlsa_col_stage #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           accept,
  input  logic [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  rlsa_pkg::rlsa_item_t           item_in,
  input  logic [rlsa_pkg::RUN_W-1:0]     v_thresh,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_pixel,
  output logic [rlsa_pkg::RUN_W-1:0]     out_row_fill,
  output logic [rlsa_pkg::RUN_W-1:0]     out_col_fill,
  output logic                           out_last
);
  import rlsa_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  logic             s1_valid_r, s1_valid_nxt;
  rlsa_item_t       s1_item_r;
  logic [XW-1:0]    s1_addr_r;
  logic             fwd_r;
  rlsa_col_t        fwd_data_r;

  logic             out_valid_r, out_valid_nxt;
  logic             out_pixel_r;
  logic [RUN_W-1:0] out_row_fill_r;
  logic [RUN_W-1:0] out_col_fill_r;
  logic             out_last_r;

  logic [COL_W-1:0] ram_q;
  rlsa_col_t        col_prev, col_new;
  logic [RUN_W-1:0] col_fill;
  logic             s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // first row of a frame sees an empty column; the entry being written
  // in the cycle of the read is taken from the bypass
  always_comb begin
    if (s1_item_r.first_row) begin
      col_prev = '0;
    end else if (fwd_r) begin
      col_prev = fwd_data_r;
    end else begin
      col_prev = rlsa_col_t'(ram_q);
    end
    col_fill = '0;
    if (s1_item_r.pixel) begin
      if (col_prev.seen && (col_prev.run <= v_thresh)) begin
        col_fill = col_prev.run;
      end
      col_new.seen = 1'b1;
      col_new.run  = '0;
    end else begin
      col_new.seen = col_prev.seen;
      col_new.run  = run_inc(col_prev.run);
    end
  end

  rlsa_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (COL_W'(col_new)),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fwd_r <= s1_adv && (s1_addr_r == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= item_in;
      s1_addr_r  <= rd_addr;
      fwd_data_r <= col_new;
    end
    if (s1_adv) begin
      out_pixel_r    <= s1_item_r.pixel;
      out_row_fill_r <= s1_item_r.row_fill;
      out_col_fill_r <= col_fill;
      out_last_r     <= s1_item_r.last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pixel_r;
  assign out_row_fill = out_row_fill_r;
  assign out_col_fill = out_col_fill_r;
  assign out_last     = out_last_r;

endmodule

// ===== test/tb_rlsa_run_length_smear_unit.sv =====
// ----------------------------------------------------------------------------
// tb_rlsa_run_length_smear_unit
// Self-checking bench for the run-length smear unit.
// ----------------------------------------------------------------------------
// Streams binary pixels through the unit under random valid/stall idling and
// predicts the pass-through pixel, row and column fill lengths and the frame
// end marker for every accepted pixel. The frame size and both thresholds are
// rewritten between bursts, including zero, oversized and mid-frame changes.
// Every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rlsa_run_length_smear_unit;
  import rlsa_pkg::*;

  localparam int MAX_COLS       = 4096;
  localparam int MAX_ROWS       = 4096;
  localparam int NUM_SEGMENTS   = 18;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AT        = 250;
  localparam int HOLD_LEN       = 300;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic             pixel;
    logic [RUN_W-1:0] row_fill;
    logic [RUN_W-1:0] col_fill;
    logic             last;
  } smear_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_pixel_black;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_pixel_out;
  logic [RUN_W-1:0]      out_row_fill_length;
  logic [RUN_W-1:0]      out_column_fill_length;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // stimulus and expectations
  logic          pixels_to_send[$];
  smear_result_t expected_fills[$];
  logic          pix_taken;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_left;
  bit            hold_done;

  // predicted block state
  logic [RUN_W-1:0]      h_thresh_q;
  logic [RUN_W-1:0]      v_thresh_q;
  logic [CFG_DATA_W-1:0] frame_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  int                    col_pos;
  int                    row_pos;
  logic [RUN_W-1:0]      row_run;
  logic                  row_seen;
  logic [RUN_W-1:0]      col_runs[MAX_COLS];
  logic                  col_black[MAX_COLS];
  int                    cols_written;

  // run statistics
  int pixels_in;
  int mismatch_count;
  int frames_closed;
  int row_fills;
  int col_fills;
  int settings_count;

  rlsa_run_length_smear_unit #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pixel_black        (in_pixel_black),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pixel_out         (out_pixel_out),
    .out_row_fill_length   (out_row_fill_length),
    .out_column_fill_length(out_column_fill_length),
    .out_frame_last        (out_frame_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [CFG_DATA_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] v,
                                                     input int limit);
    if (v == 0) return CFG_DATA_W'(1);
    if (v > limit) return CFG_DATA_W'(limit);
    return v;
  endfunction

  function automatic logic [RUN_W-1:0] grow_run(input logic [RUN_W-1:0] r);
    return (r == RUN_MAX) ? r : r + 1'b1;
  endfunction

  // works out the result of one accepted pixel and advances the raster position
  function automatic void predict_smear(input logic black);
    logic [CFG_DATA_W-1:0] w_eff;
    logic [CFG_DATA_W-1:0] h_eff;
    logic [RUN_W-1:0]      c_run;
    logic                  c_seen;
    logic                  row_end;
    logic                  frame_end;
    smear_result_t         r;
    w_eff  = eff_size(frame_width_q, MAX_COLS);
    h_eff  = eff_size(frame_height_q, MAX_ROWS);
    c_run  = '0;
    c_seen = 1'b0;
    r      = '0;
    // row 0 ignores whatever the column memory holds
    if (row_pos != 0) begin
      c_run  = col_runs[col_pos];
      c_seen = col_black[col_pos];
    end
    r.pixel = black;
    if (black) begin
      if (row_seen && row_run <= h_thresh_q) r.row_fill = row_run;
      if (c_seen && c_run <= v_thresh_q) r.col_fill = c_run;
      row_run  = '0;
      row_seen = 1'b1;
      c_run    = '0;
      c_seen   = 1'b1;
    end else begin
      row_run = grow_run(row_run);
      c_run   = grow_run(c_run);
    end
    col_runs[col_pos]  = c_run;
    col_black[col_pos] = c_seen;
    if (col_pos + 1 > cols_written) cols_written = col_pos + 1;
    row_end   = (col_pos + 1 >= w_eff);
    frame_end = row_end && (row_pos + 1 >= h_eff);
    r.last    = frame_end;
    expected_fills.push_back(r);
    if (row_end) begin
      col_pos  = 0;
      row_run  = '0;
      row_seen = 1'b0;
      row_pos  = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void note_mismatch(input string what, input smear_result_t want,
                                        input smear_result_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch %0d (%s): exp pix=%0d row=%0d col=%0d last=%0d,",
               mismatch_count, what, want.pixel, want.row_fill, want.col_fill, want.last,
               " got pix=%0d row=%0d col=%0d last=%0d",
               got.pixel, got.row_fill, got.col_fill, got.last);
  endfunction

  function automatic void compare_smear();
    smear_result_t want;
    smear_result_t got;
    got = {out_pixel_out, out_row_fill_length, out_column_fill_length, out_frame_last};
    if (expected_fills.size() == 0) begin
      note_mismatch("nothing expected", '0, got);
      return;
    end
    want = expected_fills.pop_front();
    if (want.last) frames_closed++;
    if (want.row_fill != 0) row_fills++;
    if (want.col_fill != 0) col_fills++;
    if (got.pixel !== want.pixel || got.row_fill !== want.row_fill ||
        got.col_fill !== want.col_fill || got.last !== want.last)
      note_mismatch("field", want, got);
  endfunction

  // monitor: records accepted pixels and checks accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_taken <= 1'b0;
    end else begin
      pix_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_smear(in_pixel_black);
        pixels_in++;
      end
      if (out_valid && !out_stall) compare_smear();
    end
  end

  // driver: offers the next pending pixel once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || pix_taken)) begin
      if (pixels_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_pixel_black <= pixels_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the unit up
  always @(negedge clk) begin
    if (!hold_done && pixels_in >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_H_THRESH:     h_thresh_q     = data[RUN_W-1:0];
      REG_V_THRESH:     v_thresh_q     = data[RUN_W-1:0];
      REG_FRAME_WIDTH:  frame_width_q  = data;
      REG_FRAME_HEIGHT: frame_height_q = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] hv, input logic [CFG_DATA_W-1:0] vv,
                           input logic [CFG_DATA_W-1:0] wv, input logic [CFG_DATA_W-1:0] htv);
    write_reg(REG_H_THRESH, hv);
    write_reg(REG_V_THRESH, vv);
    write_reg(REG_FRAME_WIDTH, wv);
    write_reg(REG_FRAME_HEIGHT, htv);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // msb goes out first
  task automatic push_pattern(input logic [31:0] bits, input int n);
    @(posedge clk);
    for (int i = n - 1; i >= 0; i--) pixels_to_send.push_back(bits[i]);
  endtask

  task automatic push_random(input int count, input int dens);
    @(posedge clk);
    for (int i = 0; i < count; i++) pixels_to_send.push_back($urandom_range(99, 0) < dens);
  endtask

  task automatic wait_drained();
    while (pixels_to_send.size() != 0 || in_valid || expected_fills.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void set_idle(input int seg);
    if (seg < NUM_SEGMENTS / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 45;
    end else if (seg < 2 * NUM_SEGMENTS / 3) begin
      send_idle_pct = 45;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    logic [CFG_DATA_W-1:0] v;
    int                    r;
    r = $urandom_range(99, 0);
    v = CFG_DATA_W'($urandom_range(10, 0));
    if (r >= 70 && r < 80) v = '0;
    else if (r >= 80 && r < 90) v = 13'd4095;
    else if (r >= 90) v[CFG_DATA_W-1] = 1'b1;  // top bit is not part of a threshold
    return v;
  endfunction

  initial begin
    int                    count;
    int                    dens;
    logic [CFG_DATA_W-1:0] hv;
    logic [CFG_DATA_W-1:0] vv;
    logic [CFG_DATA_W-1:0] wv;
    logic [CFG_DATA_W-1:0] htv;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_black = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    h_thresh_q     = H_THRESH_RST;
    v_thresh_q     = V_THRESH_RST;
    frame_width_q  = FRAME_WIDTH_RST;
    frame_height_q = FRAME_HEIGHT_RST;
    col_pos        = 0;
    row_pos        = 0;
    row_run        = '0;
    row_seen       = 1'b0;
    cols_written   = 0;
    set_idle(0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a few pixels under the reset settings, then a narrower frame mid-row
    push_pattern(32'b101001, 6);
    wait_drained();
    configure(13'd2, 13'd1, 13'd5, 13'd3);
    // ends row 0, then two rows with filled, unfilled and empty gaps
    push_pattern(32'b1_10001_10101, 11);
    wait_drained();
    // zero sizes act as a one-pixel frame
    configure(13'd2, 13'd1, 13'd0, 13'd0);
    push_pattern(32'b10, 2);
    wait_drained();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      set_idle(seg);
      hv    = pick_threshold();
      vv    = pick_threshold();
      wv    = CFG_DATA_W'($urandom_range(12, 1));
      htv   = CFG_DATA_W'($urandom_range(10, 1));
      dens  = $urandom_range(75, 15);
      count = $urandom_range(120, 70);
      case (seg)
        0: begin
          // oversized width, the next setting cuts the row short
          hv    = 13'd4095;
          vv    = 13'd4095;
          wv    = 13'h1fff;
          htv   = 13'd2;
          count = 50;
        end
        4: begin
          // single column, oversized height
          wv    = 13'd1;
          htv   = 13'h1fff;
          vv    = 13'd4095;
          count = 90;
        end
        8: begin
          wv  = '0;
          htv = '0;
        end
        9: begin
          wv    = CFG_DATA_W'(MAX_COLS);
          htv   = 13'd2;
          count = 60;
        end
        11: begin
          hv = '0;
          vv = '0;
        end
        14: htv = CFG_DATA_W'(MAX_ROWS);
        default: ;
      endcase
      // never widen past columns that hold data while below row 0
      if (row_pos != 0 && eff_size(wv, MAX_COLS) > cols_written)
        wv = CFG_DATA_W'(cols_written);
      configure(hv, vv, wv, htv);
      push_random(count, dens);
      wait_drained();
    end

    $display("run covered %0d pixels over %0d settings: %0d frames, %0d row and %0d column fills",
             pixels_in, settings_count, frames_closed, row_fills, col_fills);
    $display("output held off for %0d cycles once; %0d mismatches", HOLD_LEN, mismatch_count);
    if (mismatch_count == 0 && expected_fills.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
